FILE: src/hds_pkg.sv
// Shared widths, register indexes and result type for the heat diffusion stencil step core.
package hds_pkg;

  localparam int TEMP_W     = 32;
  localparam int GW_W       = 6;
  localparam int GH_W       = 16;
  localparam int COEF_W     = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Differences and product terms carry two guard bits above the temperature width.
  localparam int DIFF_W = TEMP_W + 2;
  localparam int PROD_W = DIFF_W + COEF_W + 1;
  localparam int SUM_W  = DIFF_W + 2;
  localparam int FRAC_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_X      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y      = 2'd3;

  localparam logic [GW_W-1:0] MIN_GRID_WIDTH  = 6'd3;
  localparam logic [GH_W-1:0] MIN_GRID_HEIGHT = 16'd3;

  localparam logic signed [SUM_W-1:0] SAT_MAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] SAT_MIN = -36'sh0_8000_0000;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     last;
  } res_t;

endpackage

FILE: src/heat_diffusion_stencil_step_core.sv
// Top level of the streaming FTCS five-point heat diffusion step.
//
// Streams one grid temperature per transaction in raster order (row by row, column 0
// first) and returns one explicit time step of the 2-D heat equation: every interior
// cell becomes T + cx*(E+W-2T) + cy*(N+S-2T), every boundary cell gives zero. Values
// are signed Q16.16, coefficients unsigned Q0.16 held in 15 bits (below 0.5); each
// product is floored by 2^16 and the final sum saturates to 32 bits. Two line memories
// of MAX_WIDTH entries hold the two rows above the input, so results lag the input by
// grid_width+1 cells: the first grid_width+1 inputs of a frame give no result. The
// frame's last input is followed by grid_width+1 boundary zeros, the final one flagged
// by last_o. Throughput is one cell per clock while the skid register is empty; after
// the last input of a frame the input stalls while the flush counter drains those
// trailing zeros. Each result is registered in the output register, or in a one-entry
// skid register while the output is held; the two separate the channels, so input
// keeps flowing while one result waits. Writing grid_width or grid_height restarts
// the frame; writes are expected only while the core is idle. Out-of-range geometry
// is clamped (width to 3..MAX_WIDTH, height to at least 3); the config port is always ready.
module heat_diffusion_stencil_step_core
  import hds_pkg::*;
#(
  parameter int MAX_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input cell stream
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [TEMP_W-1:0]     temp_in_i,
  // result stream
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [TEMP_W-1:0]     temp_out_o,
  output logic                         last_o,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int FW = $clog2(MAX_WIDTH + 2);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [GW_W-1:0]   grid_width_q;
  logic [GH_W-1:0]   grid_height_q;
  logic [COEF_W-1:0] coef_x_q;
  logic [COEF_W-1:0] coef_y_q;
  logic              cfg_we;
  logic              geom_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  // A geometry write restarts the frame position.
  assign geom_we     = cfg_we &
                       ((cfg_index_i == CFG_GRID_WIDTH) || (cfg_index_i == CFG_GRID_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= 6'd4;
      grid_height_q <= 16'd4;
      coef_x_q      <= 15'd16384;
      coef_y_q      <= 15'd4096;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i[GW_W-1:0];
        CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i[GH_W-1:0];
        CFG_COEF_X:      coef_x_q      <= cfg_data_i[COEF_W-1:0];
        CFG_COEF_Y:      coef_y_q      <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry to the supported range.
  logic [GW_W-1:0] eff_w;
  logic [GH_W-1:0] eff_h;

  always_comb begin
    if (grid_width_q < MIN_GRID_WIDTH) begin
      eff_w = MIN_GRID_WIDTH;
    end else if (grid_width_q > GW_W'(MAX_WIDTH)) begin
      eff_w = GW_W'(MAX_WIDTH);
    end else begin
      eff_w = grid_width_q;
    end
    eff_h = (grid_height_q < MIN_GRID_HEIGHT) ? MIN_GRID_HEIGHT : grid_height_q;
  end

  // ---------------------------------------------------------------------------
  // Handshake and frame position
  // ---------------------------------------------------------------------------
  logic [CW-1:0]   col_q, col_d;
  logic [GH_W-1:0] row_q, row_d;
  logic [CW-1:0]   c_cur;
  logic [GH_W-1:0] r_cur;
  logic [GW_W-1:0] c_next;
  logic [FW-1:0]   flush_cnt_q, flush_cnt_d;
  logic            flush_go;
  logic            skid_valid_q;
  logic            accept;
  logic            frame_end;

  assign in_stall_o = skid_valid_q | (flush_cnt_q != '0);
  assign accept     = in_valid_i & ~in_stall_o;

  assign c_cur     = (GW_W'(col_q) >= eff_w) ? '0 : col_q;
  assign r_cur     = (row_q >= eff_h) ? '0 : row_q;
  assign frame_end = (r_cur == eff_h - GH_W'(1)) && (GW_W'(c_cur) == eff_w - GW_W'(1));
  assign c_next    = GW_W'(c_cur) + GW_W'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (geom_we) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (frame_end) begin
        col_d = '0;
        row_d = '0;
      end else if (c_next >= eff_w) begin
        col_d = '0;
        row_d = r_cur + GH_W'(1);
      end else begin
        col_d = c_next[CW-1:0];
        row_d = r_cur;
      end
    end
  end

  // Drain the trailing boundary zeros one per cycle while the output path has room.
  assign flush_go = (flush_cnt_q != '0) & ~skid_valid_q;

  always_comb begin
    flush_cnt_d = flush_cnt_q;
    if (accept && frame_end) begin
      flush_cnt_d = FW'(eff_w) + FW'(1);
    end else if (flush_go) begin
      flush_cnt_d = flush_cnt_q - FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      flush_cnt_q <= '0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      flush_cnt_q <= flush_cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line memories: upper holds row r-2, lower row r-1. Registered reads use the column
  // of the next cell; the write hits another column unless a geometry write meets column 0.
  // ---------------------------------------------------------------------------
  logic signed [TEMP_W-1:0] upper_mem [MAX_WIDTH];
  logic signed [TEMP_W-1:0] lower_mem [MAX_WIDTH];
  logic signed [TEMP_W-1:0] upper_rd_q;
  logic signed [TEMP_W-1:0] lower_rd_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      upper_mem[c_cur] <= lower_rd_q;
      lower_mem[c_cur] <= temp_in_i;
    end
    upper_rd_q <= upper_mem[col_d];
    lower_rd_q <= lower_mem[col_d];
  end

  // Stencil window: center and west of the row above, north, and south (last input).
  logic signed [TEMP_W-1:0] win_c_q;
  logic signed [TEMP_W-1:0] win_w_q;
  logic signed [TEMP_W-1:0] win_n_q;
  logic signed [TEMP_W-1:0] win_s_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_w_q <= win_c_q;
      win_c_q <= lower_rd_q;
      win_n_q <= upper_rd_q;
      win_s_q <= temp_in_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stencil arithmetic (all operands come from registers)
  // ---------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] t_ext, e_ext, w_ext, n_ext, s_ext;
  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [DIFF_W-1:0] px, py;
  logic signed [SUM_W-1:0]  sum;
  logic signed [TEMP_W-1:0] sat_val;
  logic                     res_gen;
  logic                     interior;

  assign t_ext = {{2{win_c_q[TEMP_W-1]}}, win_c_q};
  assign e_ext = {{2{lower_rd_q[TEMP_W-1]}}, lower_rd_q};
  assign w_ext = {{2{win_w_q[TEMP_W-1]}}, win_w_q};
  assign n_ext = {{2{win_n_q[TEMP_W-1]}}, win_n_q};
  assign s_ext = {{2{win_s_q[TEMP_W-1]}}, win_s_q};

  assign dx = e_ext + w_ext - (t_ext <<< 1);
  assign dy = n_ext + s_ext - (t_ext <<< 1);

  assign prod_x = $signed({1'b0, coef_x_q}) * dx;
  assign prod_y = $signed({1'b0, coef_y_q}) * dy;

  // Floor by 2^16: keep the upper bits of the two's complement product.
  assign px = prod_x[FRAC_W +: DIFF_W];
  assign py = prod_y[FRAC_W +: DIFF_W];

  assign sum = {{2{t_ext[DIFF_W-1]}}, t_ext} + {{2{px[DIFF_W-1]}}, px}
             + {{2{py[DIFF_W-1]}}, py};

  always_comb begin
    if (sum > SAT_MAX) begin
      sat_val = SAT_MAX[TEMP_W-1:0];
    end else if (sum < SAT_MIN) begin
      sat_val = SAT_MIN[TEMP_W-1:0];
    end else begin
      sat_val = sum[TEMP_W-1:0];
    end
  end

  // A result exists once the window has passed the first row and one cell.
  assign res_gen  = (r_cur >= GH_W'(2)) || ((r_cur == GH_W'(1)) && (c_cur != '0));
  assign interior = (GW_W'(c_cur) >= GW_W'(2)) && (r_cur >= GH_W'(2)) &&
                    (r_cur <= eff_h - GH_W'(1));

  // ---------------------------------------------------------------------------
  // Result producer, output register and skid register
  // ---------------------------------------------------------------------------
  logic prod_valid;
  res_t prod;
  res_t out_q, skid_q;
  logic out_valid_q;
  logic out_take;
  logic out_load;

  always_comb begin
    if (accept) begin
      prod_valid = res_gen;
      prod.temp  = interior ? sat_val : '0;
      prod.last  = 1'b0;
    end else begin
      prod_valid = flush_go;
      prod.temp  = '0;
      prod.last  = (flush_cnt_q == FW'(1));
    end
  end

  assign out_take = out_valid_q & ~out_stall_i;
  assign out_load = ~out_valid_q | out_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_load) begin
      // Empty the skid first; a new result only arrives while the skid is empty.
      out_valid_q  <= skid_valid_q | prod_valid;
      skid_valid_q <= 1'b0;
    end else if (prod_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_valid_q ? skid_q : prod;
    end else if (prod_valid) begin
      skid_q <= prod;
    end
  end

  assign out_valid_o = out_valid_q;
  assign temp_out_o  = out_q.temp;
  assign last_o      = out_q.last;

`ifndef NO_ASSERTIONS
  // The skid register only fills behind a held output.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register valid while output register empty");

  // The frame-end flag only rides on a boundary zero.
  a_last_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (temp_out_o == '0))
    else $error("last result carries a nonzero temperature");

  // While trailing zeros drain, the position is parked at the frame start.
  a_flush_parks_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flush_cnt_q != '0) |-> ((col_q == '0) && (row_q == '0)))
    else $error("frame position moved during flush");

  // The column counter stays inside the effective row width.
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    GW_W'(col_q) < eff_w)
    else $error("column counter beyond grid width");
`endif

endmodule
